### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they expand to nothing
// when the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/rs485hd_pkg.sv
// ----------------------------------------------------------------------------
// RS485 half-duplex buffer package
// Ring depths, field widths, operation codes and pin-count codes.
// ----------------------------------------------------------------------------
package rs485hd_pkg;

	// Ring depths; each ring keeps one slot empty.
	localparam int RX_DEPTH = 64;
	localparam int TX_DEPTH = 64;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int TX_AW    = $clog2(TX_DEPTH);

	// Field widths.
	localparam int DATA_W  = 8;
	localparam int OP_W    = 3;
	localparam int COUNT_W = 6;
	localparam int PIN_W   = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_RX_BYTE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ    = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
	localparam logic [OP_W-1:0] OP_SENT    = 3'd4;
	localparam logic [OP_W-1:0] OP_DISCARD = 3'd5;

	// Direction pin counts.
	localparam logic [PIN_W-1:0] PINS_DRIVER = 2'd1;
	localparam logic [PIN_W-1:0] PINS_BOTH   = 2'd2;

endpackage

### sv/rs485_half_duplex_uart_buffers.sv
// ----------------------------------------------------------------------------
// RS485 half-duplex UART buffers
// Receive and transmit byte rings with driver and receiver enable control.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Its result appears
// on the result ports, marked by done for exactly one cycle, once the update
// cycle is over. The receiver cannot stall, so the result must be captured in
// that cycle. busy is high in the execute state after each transfer, so the block
// cannot take a new operation until the last one is through. This is set by
// the registered read of the two ring memories: each operation reads its ring
// entry at the transfer and updates pointers and memory in the following cycle.
// The enable pin count (pin_count_q) is written through cfg_write and cfg_data;
// the user must write it only while idle, as the block does not enforce this.

`include "assert_macros.svh"

module rs485_half_duplex_uart_buffers (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [rs485hd_pkg::OP_W-1:0]     op,
	input  logic [rs485hd_pkg::DATA_W-1:0]   data,
	input  logic                             rx_error,
	input  logic                             cfg_write,
	input  logic [rs485hd_pkg::PIN_W-1:0]    cfg_data,
	output logic [rs485hd_pkg::DATA_W-1:0]   read_data,
	output logic                             read_valid,
	output logic                             write_accepted,
	output logic [rs485hd_pkg::COUNT_W-1:0]  rx_count,
	output logic [rs485hd_pkg::COUNT_W-1:0]  tx_space,
	output logic [rs485hd_pkg::DATA_W-1:0]   line_byte,
	output logic                             line_start,
	output logic                             driver_enable,
	output logic                             receiver_disable
);
	import rs485hd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// Control state.
	state_t             state_q;
	logic [RX_AW-1:0]   rx_wp_q, rx_rp_q;
	logic [TX_AW-1:0]   tx_wp_q, tx_rp_q;
	logic               tx_busy_q, driving_q;
	logic [PIN_W-1:0]   pin_count_q;
	logic               done_q;

	// Operation captured at the transfer.
	logic [OP_W-1:0]    op_s1;
	logic [DATA_W-1:0]  data_s1;
	logic               err_s1;
	logic [DATA_W-1:0]  rx_rdata_s1, tx_rdata_s1;

	// Ring memories.
	logic [DATA_W-1:0]  rx_mem [RX_DEPTH];
	logic [DATA_W-1:0]  tx_mem [TX_DEPTH];

	// Next state and results.
	logic [RX_AW-1:0]   rx_wp_d, rx_rp_d, rx_used;
	logic [TX_AW-1:0]   tx_wp_d, tx_rp_d, tx_used, tx_raddr;
	logic               tx_busy_d, driving_d, rx_we, tx_we;
	logic [DATA_W-1:0]  rdata_d, lbyte_d;
	logic               rvalid_d, wacc_d, lstart_d;
	logic               accept, exec;

	// Result registers.
	logic [DATA_W-1:0]  read_data_q, line_byte_q;
	logic               read_valid_q, write_accepted_q, line_start_q;
	logic [COUNT_W-1:0] rx_count_q, tx_space_q;
	logic               driver_enable_q, receiver_disable_q;

	// Ring pointer increments with wrap at the depth.
	function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
		if (p == RX_AW'(RX_DEPTH - 1)) return '0;
		else return p + RX_AW'(1);
	endfunction

	function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
		if (p == TX_AW'(TX_DEPTH - 1)) return '0;
		else return p + TX_AW'(1);
	endfunction

	assign exec   = (state_q == ST_EXEC);
	assign busy   = exec;
	assign accept = start && !busy;

	// A byte-sent operation reads the entry after the current one.
	assign tx_raddr = (op == OP_SENT) ? tx_inc(tx_rp_q) : tx_rp_q;

	// Sequencer: the rings are read at the transfer and updated in the execute state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_count_q <= '0;
		end else if (cfg_write) begin
			pin_count_q <= cfg_data;
		end
	end

	// Capture the operation at the transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			data_s1 <= data;
			err_s1  <= rx_error;
		end
	end

	// Receive ring memory: read at the transfer, written in the update cycle.
	always_ff @(posedge clk) begin
		if (rx_we) rx_mem[rx_wp_q] <= data_s1;
		if (accept) rx_rdata_s1 <= rx_mem[rx_rp_q];
	end

	// Transmit ring memory: read at the transfer, written in the update cycle.
	always_ff @(posedge clk) begin
		if (tx_we) tx_mem[tx_wp_q] <= data_s1;
		if (accept) tx_rdata_s1 <= tx_mem[tx_raddr];
	end

	// Operation decode and next ring state.
	always_comb begin
		rx_wp_d   = rx_wp_q;
		rx_rp_d   = rx_rp_q;
		tx_wp_d   = tx_wp_q;
		tx_rp_d   = tx_rp_q;
		tx_busy_d = tx_busy_q;
		driving_d = driving_q;
		rx_we     = 1'b0;
		tx_we     = 1'b0;
		rdata_d   = '0;
		rvalid_d  = 1'b0;
		wacc_d    = 1'b0;
		lbyte_d   = '0;
		lstart_d  = 1'b0;
		if (exec) begin
			unique case (op_s1) inside
				OP_RX_BYTE: begin
					if (!err_s1 && rx_inc(rx_wp_q) != rx_rp_q) begin
						rx_we   = 1'b1;
						rx_wp_d = rx_inc(rx_wp_q);
					end
				end
				OP_READ, OP_PEEK: begin
					if (rx_wp_q != rx_rp_q) begin
						rdata_d  = rx_rdata_s1;
						rvalid_d = 1'b1;
						if (op_s1 == OP_READ) rx_rp_d = rx_inc(rx_rp_q);
					end
				end
				OP_WRITE: begin
					if (tx_inc(tx_wp_q) != tx_rp_q) begin
						tx_we   = 1'b1;
						tx_wp_d = tx_inc(tx_wp_q);
						wacc_d  = 1'b1;
						if (!tx_busy_q) begin
							tx_busy_d = 1'b1;
							driving_d = 1'b1;
							lstart_d  = 1'b1;
							// The oldest byte may be the one written in this cycle.
							lbyte_d   = (tx_wp_q == tx_rp_q) ? data_s1 : tx_rdata_s1;
						end
					end
				end
				OP_SENT: begin
					if (tx_busy_q) begin
						tx_rp_d = tx_inc(tx_rp_q);
						if (tx_rp_d == tx_wp_q) begin
							tx_busy_d = 1'b0;
							driving_d = 1'b0;
						end else begin
							lbyte_d  = tx_rdata_s1;
							lstart_d = 1'b1;
						end
					end
				end
				OP_DISCARD: rx_rp_d = rx_wp_q;
				default: ;
			endcase
		end
	end

	// Fill levels after the update; arithmetic wraps within the pointer width.
	always_comb begin
		if (rx_wp_d >= rx_rp_d) rx_used = rx_wp_d - rx_rp_d;
		else rx_used = rx_wp_d + RX_AW'(RX_DEPTH) - rx_rp_d;
		if (tx_wp_d >= tx_rp_d) tx_used = tx_wp_d - tx_rp_d;
		else tx_used = tx_wp_d + TX_AW'(TX_DEPTH) - tx_rp_d;
	end

	// Ring pointers and transmitter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q   <= '0;
			rx_rp_q   <= '0;
			tx_wp_q   <= '0;
			tx_rp_q   <= '0;
			tx_busy_q <= 1'b0;
			driving_q <= 1'b0;
		end else if (exec) begin
			rx_wp_q   <= rx_wp_d;
			rx_rp_q   <= rx_rp_d;
			tx_wp_q   <= tx_wp_d;
			tx_rp_q   <= tx_rp_d;
			tx_busy_q <= tx_busy_d;
			driving_q <= driving_d;
		end
	end

	// Result registers, loaded at the end of the update cycle.
	always_ff @(posedge clk) begin
		if (exec) begin
			read_data_q        <= rdata_d;
			read_valid_q       <= rvalid_d;
			write_accepted_q   <= wacc_d;
			rx_count_q         <= COUNT_W'(rx_used);
			tx_space_q         <= COUNT_W'(TX_AW'(TX_DEPTH - 1) - tx_used);
			line_byte_q        <= lbyte_d;
			line_start_q       <= lstart_d;
			driver_enable_q    <= driving_d && (pin_count_q >= PINS_DRIVER);
			receiver_disable_q <= driving_d && (pin_count_q >= PINS_BOTH);
		end
	end

	assign done             = done_q;
	assign read_data        = read_data_q;
	assign read_valid       = read_valid_q;
	assign write_accepted   = write_accepted_q;
	assign rx_count         = rx_count_q;
	assign tx_space         = tx_space_q;
	assign line_byte        = line_byte_q;
	assign line_start       = line_start_q;
	assign driver_enable    = driver_enable_q;
	assign receiver_disable = receiver_disable_q;

	// Every update cycle is followed by exactly one result strobe.
	`ASSERT_NEXT(a_done_after_exec, clk, arst_n, state_q == ST_EXEC, done_q, "result strobe missing after update cycle")

	// An idle transmitter always has an empty transmit ring.
	`ASSERT_IMPLY(a_idle_tx_empty, clk, arst_n, !tx_busy_q, tx_rp_q == tx_wp_q, "idle transmitter with bytes queued")

	// A started byte leaves the transmitter busy and the line driven.
	`ASSERT_IMPLY(a_start_drives, clk, arst_n, done_q && line_start_q, tx_busy_q && driving_q, "byte started without driving the line")

endmodule
